>>> hw/rtl/aes_pkg.sv
// Shared types, constants and byte functions for the AES-128 round unit.
// Depends on nothing; used by the controller, the datapath and the top level.
package aes_pkg;

   typedef enum logic [2:0] {
      KIND_ENCRYPT  = 3'd0,
      KIND_ROUND    = 3'd1,
      KIND_FINAL    = 3'd2,
      KIND_KEY_STEP = 3'd3,
      KIND_ADD_KEY  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ROUND = 2'd1,
      ST_DONE  = 2'd2
   } state_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] text_hi;
      logic [63:0] text_lo;
      logic [63:0] key_hi;
      logic [63:0] key_lo;
      logic [7:0]  round_constant;
   } req_type;

   typedef struct packed {
      logic [63:0] block_hi;
      logic [63:0] block_lo;
      logic [63:0] next_key_hi;
      logic [63:0] next_key_lo;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;   // capture request, apply mode-specific first step
      logic step;   // run one encryption round
      logic last;   // the round being run is the final one
   } cmd_type;

   localparam int unsigned ROUND_COUNT = 10;
   localparam int unsigned ROUND_CNT_W = 4;
   localparam logic [7:0]  RCON_FIRST  = 8'h01;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] tbl [256];
      tbl = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      sbox = tbl[x];
   endfunction

   // Byte i of a 128-bit word, byte 0 most significant.
   function automatic logic [7:0] byte_at(input logic [127:0] w, input int unsigned i);
      byte_at = w[127 - 8*i -: 8];
   endfunction

   // SubBytes and ShiftRows, then MixColumns when mix is set.
   function automatic logic [127:0] round_fn(input logic [127:0] s, input logic mix);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] r;
      for (int c = 0; c < 4; c++) begin
         for (int rw = 0; rw < 4; rw++) begin
            t[4*c + rw] = sbox(byte_at(s, 4*((c + rw) % 4) + rw));
         end
      end
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         r[127 - 8*i -: 8] = t[i];
      end
      round_fn = r;
   endfunction

   function automatic logic [127:0] key_fn(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      key_fn = {w0, w1, w2, w3};
   endfunction

endpackage

>>> hw/rtl/aes_ctrl.sv
// Sequencer for the AES-128 round unit: loads a request, counts rounds.
// Depends on aes_pkg.
module aes_ctrl
   import aes_pkg::*;
#(
   parameter int unsigned ROUNDS = ROUND_COUNT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  kind_type kind,
   output logic     busy,
   output logic     done,
   output cmd_type  cmd
);

   state_type              state_ff, state_in;
   logic [ROUND_CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cnt_in   = ROUND_CNT_W'(1);
               state_in = (kind == KIND_ENCRYPT) ? ST_ROUND : ST_DONE;
            end
         end
         ST_ROUND: begin
            cnt_in = cnt_ff + ROUND_CNT_W'(1);
            if (cnt_ff == ROUND_CNT_W'(ROUNDS)) state_in = ST_DONE;
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy     = 1'b1;
      done     = 1'b0;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_ROUND: begin
            cmd.step = 1'b1;
            cmd.last = (cnt_ff == ROUND_CNT_W'(ROUNDS));
         end
         ST_DONE:  done = 1'b1;
         default:  done = 1'b0;
      endcase
   end

endmodule

>>> hw/rtl/aes_dpath.sv
// Datapath of the AES-128 round unit: state, key and Rcon registers, with
// combinational round and key-expansion logic. Depends on aes_pkg.
module aes_dpath
   import aes_pkg::*;
(
   input  logic    clock,
   input  req_type req,
   input  cmd_type cmd,
   output rsp_type rsp
);

   logic [127:0] st_ff, st_in;
   logic [127:0] key_ff, key_in;
   logic [7:0]   rc_ff, rc_in;
   logic [127:0] nkey;
   logic [127:0] txt, kin;

   assign txt  = {req.text_hi, req.text_lo};
   assign kin  = {req.key_hi, req.key_lo};
   assign nkey = key_fn(key_ff, rc_ff);

   always_comb begin
      st_in  = st_ff;
      key_in = key_ff;
      rc_in  = rc_ff;
      if (cmd.load) begin
         rc_in  = RCON_FIRST;
         key_in = '0;
         case (kind_type'(req.kind))
            KIND_ENCRYPT: begin
               st_in  = txt ^ kin;
               key_in = kin;
            end
            KIND_ROUND:    st_in = round_fn(txt, 1'b1) ^ kin;
            KIND_FINAL:    st_in = round_fn(txt, 1'b0) ^ kin;
            KIND_KEY_STEP: begin
               st_in  = '0;
               key_in = key_fn(kin, req.round_constant);
            end
            KIND_ADD_KEY:  st_in = txt ^ kin;
            default:       st_in = '0;
         endcase
      end else if (cmd.step) begin
         // advance key and state together
         st_in  = round_fn(st_ff, !cmd.last) ^ nkey;
         key_in = cmd.last ? '0 : nkey;
         rc_in  = xtime(rc_ff);
      end
   end

   always_ff @(posedge clock) begin
      st_ff  <= st_in;
      key_ff <= key_in;
      rc_ff  <= rc_in;
   end

   assign rsp = '{block_hi: st_ff[127:64], block_lo: st_ff[63:0],
                  next_key_hi: key_ff[127:64], next_key_lo: key_ff[63:0]};

endmodule

>>> hw/rtl/aes128_encrypt_round_unit.sv
// Top level of the AES-128 round unit: controller plus datapath.
// Depends on aes_pkg, aes_ctrl and aes_dpath.
//
//   channel   ports                          handshake
//   request   req_payload                    start & !busy
//   result    rsp_payload                    rsp_strobe (one cycle, no stall)
//
// Full encryption: the round-zero key add happens at the request transfer edge,
// then the controller runs the rounds in ST_ROUND on the round logic and gives
// the result strobe in ST_DONE. The other kinds go straight to ST_DONE and
// give the result transfer in the cycle after the request transfer. The
// controller returns to ST_IDLE after the strobe and takes the next request
// only there, so it never takes a new request before the last result is given.
// Reset is synchronous and clears the controller only. The receiver cannot
// stall; busy stays high until the result strobe has been given.
module aes128_encrypt_round_unit
   import aes_pkg::*;
#(
   parameter int unsigned ROUNDS = ROUND_COUNT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   cmd_type cmd;

   aes_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .kind  (kind_type'(req_payload.kind)),
      .busy  (busy),
      .done  (rsp_strobe),
      .cmd   (cmd)
   );

   aes_dpath u_dpath (
      .clock (clock),
      .req   (req_payload),
      .cmd   (cmd),
      .rsp   (rsp_payload)
   );

endmodule
